// ----- rtl/core/ldc_pkg.sv -----
// Shared types, register indexes and helper functions of the breathing LED dimmer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ldc_pkg;

  localparam int LDC_QDEPTH = 2;

  localparam int LDC_CFG_IDX_W  = 3;
  localparam int LDC_CFG_DATA_W = 16;

  localparam logic [LDC_CFG_IDX_W-1:0] CFG_LED_MODE     = 3'd0;
  localparam logic [LDC_CFG_IDX_W-1:0] CFG_BASE_GREEN   = 3'd1;
  localparam logic [LDC_CFG_IDX_W-1:0] CFG_BASE_BLUE    = 3'd2;
  localparam logic [LDC_CFG_IDX_W-1:0] CFG_PERIOD_MS    = 3'd3;
  localparam logic [LDC_CFG_IDX_W-1:0] CFG_PRESS_ENABLE = 3'd4;
  localparam logic [LDC_CFG_IDX_W-1:0] CFG_PRESS_GREEN  = 3'd5;
  localparam logic [LDC_CFG_IDX_W-1:0] CFG_PRESS_BLUE   = 3'd6;
  localparam logic [LDC_CFG_IDX_W-1:0] CFG_BRIGHTNESS   = 3'd7;

  localparam logic [1:0] MODE_SOLID   = 2'd0;
  localparam logic [1:0] MODE_BREATHE = 2'd1;
  localparam logic [1:0] MODE_CYCLE   = 2'd2;
  localparam logic [1:0] MODE_OFF     = 2'd3;

  localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;
  localparam logic [7:0] LEVEL_MAX        = 8'd255;
  localparam logic [7:0] PHASE_HALF       = 8'd128;

  typedef struct packed {
    logic [1:0]  led_mode;
    logic [7:0]  base_green;
    logic [7:0]  base_blue;
    logic [15:0] period_ms;
    logic        press_enable;
    logic [7:0]  press_green;
    logic [7:0]  press_blue;
    logic [7:0]  brightness;
  } cfg_t;

  // One classified tick: breathe entries still need the wave scaling.
  typedef struct packed {
    logic       breathe;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] wave;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] tri_wave(input logic [7:0] p);
    logic [7:0] w;
    if (p < PHASE_HALF) begin
      w = {p[6:0], 1'b0};
    end else begin
      w = {~p[6:0], 1'b0};
    end
    return w;
  endfunction

  function automatic logic [7:0] mul_scale(input logic [7:0] v, input logic [7:0] by);
    logic [15:0] prod;
    prod = v * by;
    return prod[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ldc_front.sv -----
// Front end: accepts tick beats, advances the tick counter and phase, classifies the tick.
// Depends on ldc_pkg; feeds ldc_queue.
`timescale 1ns / 1ps
`default_nettype none

module ldc_front import ldc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     accept,
  input  wire logic     key_down,
  output q_entry_t      entry
);

  logic [7:0] tick_count_r, tick_count_nxt;
  logic [7:0] anim_phase_r, anim_phase_nxt;
  logic [7:0] step;
  logic [8:0] cnt;
  logic       adv;
  logic [7:0] wave;

  always_comb begin
    step = (cfg.period_ms[15:8] == 8'd0) ? 8'd1 : cfg.period_ms[15:8];
    cnt  = {1'b0, tick_count_r} + 9'd1;
    adv  = cnt >= {1'b0, step};
    tick_count_nxt = adv ? 8'd0 : cnt[7:0];
    anim_phase_nxt = adv ? anim_phase_r + 8'd1 : anim_phase_r;
    wave = tri_wave(anim_phase_nxt);

    entry.breathe = 1'b0;
    entry.wave    = wave;
    entry.green   = 8'd0;
    entry.blue    = 8'd0;
    if (key_down && cfg.press_enable) begin
      entry.green = cfg.press_green;
      entry.blue  = cfg.press_blue;
    end else begin
      unique case (cfg.led_mode)
        MODE_SOLID: begin
          entry.green = cfg.base_green;
          entry.blue  = cfg.base_blue;
        end
        MODE_BREATHE: begin
          entry.breathe = 1'b1;
          entry.green   = cfg.base_green;
          entry.blue    = cfg.base_blue;
        end
        MODE_CYCLE: begin
          entry.green = LEVEL_MAX - wave;
          entry.blue  = wave;
        end
        default: begin
          entry.green = 8'd0;
          entry.blue  = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= 8'd0;
      anim_phase_r <= 8'd0;
    end else if (accept) begin
      tick_count_r <= tick_count_nxt;
      anim_phase_r <= anim_phase_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ldc_queue.sv -----
// Short queue of classified ticks between the front end and the scaling back end.
// Depends on ldc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldc_queue import ldc_pkg::*; #(
  parameter int DEPTH = LDC_QDEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_stat_t       stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head       = mem[rd_ptr_r];
  assign stat.full  = count_r == FULL_CNT;
  assign stat.empty = count_r == '0;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ldc_back.sv -----
// Back end: scales queued levels by wave and brightness on one shared 8x8 multiplier,
// then holds the result beat in the output register. Depends on ldc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldc_back import ldc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire q_entry_t   head,
  input  wire q_stat_t    stat,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_green_level,
  output logic [7:0]      out_blue_level,
  output logic [4:0]      out_green_duty,
  output logic [4:0]      out_blue_duty,
  output logic            out_led_enable
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_G1   = 3'd1;
  localparam logic [2:0] S_B1   = 3'd2;
  localparam logic [2:0] S_G2   = 3'd3;
  localparam logic [2:0] S_B2   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [7:0] g_r, b_r, w_r;
  logic [7:0] mul_a, mul_b, mul_q;
  logic       out_valid_r;
  logic [7:0] out_g_r, out_b_r;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == S_IDLE) && !stat.empty;

  always_comb begin
    mul_a = g_r;
    mul_b = cfg.brightness;
    unique case (state_r)
      S_G1: begin
        mul_a = g_r;
        mul_b = w_r;
      end
      S_B1: begin
        mul_a = b_r;
        mul_b = w_r;
      end
      S_B2: begin
        mul_a = b_r;
        mul_b = cfg.brightness;
      end
      default: begin
        mul_a = g_r;
        mul_b = cfg.brightness;
      end
    endcase
    mul_q = mul_scale(mul_a, mul_b);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (pop) state_nxt = head.breathe ? S_G1 : S_G2;
      S_G1:   state_nxt = S_B1;
      S_B1:   state_nxt = S_G2;
      S_G2:   state_nxt = S_B2;
      S_B2:   state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      g_r <= head.green;
      b_r <= head.blue;
      w_r <= head.wave;
    end else if (state_r == S_G1 || state_r == S_G2) begin
      g_r <= mul_q;
    end else if (state_r == S_B1 || state_r == S_B2) begin
      b_r <= mul_q;
    end
    if (state_r == S_OUT && out_free) begin
      out_g_r <= g_r;
      out_b_r <= b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_green_level = out_g_r;
  assign out_blue_level  = out_b_r;
  assign out_green_duty  = out_g_r[7:3];
  assign out_blue_duty   = out_b_r[7:3];
  assign out_led_enable  = (out_g_r != 8'd0) || (out_b_r != 8'd0);

endmodule

`default_nettype wire

// ----- rtl/core/led_breathe_cycle_dimmer_top.sv -----
// Top level of the breathing LED dimmer: configuration registers, front end, queue, back end.
// Depends on ldc_pkg, ldc_front, ldc_queue and ldc_back.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_key_down
//   out_     output     out_valid / out_ready levels, duties, led_enable
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// A tick beat is classified and queued in the cycle it is accepted.
// In breathe mode the back end does four multiplies on one shared 8x8
// multiplier (G1, B1, G2, B2) between pop and result beat, otherwise two (G2, B2).
// Input stalls only when the queue is full; a result waiting for out_ready
// leaves the front end and queue running. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module led_breathe_cycle_dimmer_top import ldc_pkg::*; #(
  parameter int QDEPTH = LDC_QDEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_key_down,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_green_level,
  output logic [7:0]                     out_blue_level,
  output logic [4:0]                     out_green_duty,
  output logic [4:0]                     out_blue_duty,
  output logic                           out_led_enable,
  input  wire logic                      cfg_we,
  input  wire logic [LDC_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [LDC_CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  q_entry_t entry;
  q_entry_t head;
  q_stat_t  stat;
  logic     accept;
  logic     pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_mode     <= MODE_SOLID;
      cfg_r.base_green   <= 8'd0;
      cfg_r.base_blue    <= 8'd0;
      cfg_r.period_ms    <= 16'd0;
      cfg_r.press_enable <= 1'b0;
      cfg_r.press_green  <= 8'd0;
      cfg_r.press_blue   <= 8'd0;
      cfg_r.brightness   <= BRIGHTNESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LED_MODE:     cfg_r.led_mode     <= cfg_wdata[1:0];
        CFG_BASE_GREEN:   cfg_r.base_green   <= cfg_wdata[7:0];
        CFG_BASE_BLUE:    cfg_r.base_blue    <= cfg_wdata[7:0];
        CFG_PERIOD_MS:    cfg_r.period_ms    <= cfg_wdata;
        CFG_PRESS_ENABLE: cfg_r.press_enable <= cfg_wdata[0];
        CFG_PRESS_GREEN:  cfg_r.press_green  <= cfg_wdata[7:0];
        CFG_PRESS_BLUE:   cfg_r.press_blue   <= cfg_wdata[7:0];
        CFG_BRIGHTNESS:   cfg_r.brightness   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  ldc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .key_down (in_key_down),
    .entry    (entry)
  );

  ldc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  ldc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (head),
    .stat            (stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_green_duty  (out_green_duty),
    .out_blue_duty   (out_blue_duty),
    .out_led_enable  (out_led_enable)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("back end popped an empty queue");

  a_reset_no_beat: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  a_enable_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_led_enable == (out_green_level != 8'd0 || out_blue_level != 8'd0)))
    else $error("led enable disagrees with levels");

endmodule

`default_nettype wire

// ----- test/led_breathe_cycle_dimmer_top_tb.sv -----
// Self-checking testbench for the breathing LED dimmer: frame ticks in, scaled levels out.
// Depends on ldc_pkg and led_breathe_cycle_dimmer_top; predicts every result beat itself.
`timescale 1ns / 1ps

module led_breathe_cycle_dimmer_top_tb;
  import ldc_pkg::*;

  typedef struct packed {
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [4:0] green_duty;
    logic [4:0] blue_duty;
    logic       led_enable;
  } levels_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_PRINTS     = 30;
  localparam int RAND_SETTINGS  = 30;
  localparam int TICKS_PER_SET  = 50;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_key_down = 1'b0;
  logic                      out_ready   = 1'b0;
  logic                      cfg_we      = 1'b0;
  logic [LDC_CFG_IDX_W-1:0]  cfg_index   = CFG_LED_MODE;
  logic [LDC_CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                      in_ready;
  logic                      out_valid;
  logic [7:0]                out_green_level;
  logic [7:0]                out_blue_level;
  logic [4:0]                out_green_duty;
  logic [4:0]                out_blue_duty;
  logic                      out_led_enable;

  cfg_t       regs_shadow;
  logic [7:0] tick_count;
  logic [7:0] anim_phase;
  levels_t    expected_levels[$];
  int         send_idle_pct   = 0;
  int         recv_stall_pct  = 0;
  int         mismatches      = 0;
  int         ticks_sent      = 0;
  int         results_checked = 0;
  int         override_ticks  = 0;
  int         settings_used   = 0;
  int         quiet_cycles    = 0;

  always #5 clk = ~clk;

  led_breathe_cycle_dimmer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_down     (in_key_down),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_green_duty  (out_green_duty),
    .out_blue_duty   (out_blue_duty),
    .out_led_enable  (out_led_enable),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  function automatic logic [7:0] scale8(input logic [7:0] v, input logic [7:0] by);
    logic [15:0] prod;
    prod = 16'(v) * 16'(by);
    return prod[15:8];
  endfunction

  // Advances the tick counter and phase, then forms the levels with the new phase.
  function automatic levels_t next_levels(input logic key);
    levels_t    lv;
    logic [8:0] count_next;
    logic [7:0] step;
    logic [7:0] wave;
    logic [7:0] green;
    logic [7:0] blue;
    step = (regs_shadow.period_ms < 16'd256) ? 8'd1 : regs_shadow.period_ms[15:8];
    count_next = {1'b0, tick_count} + 9'd1;
    if (count_next >= {1'b0, step}) begin
      tick_count = 8'd0;
      anim_phase = anim_phase + 8'd1;
    end else begin
      tick_count = count_next[7:0];
    end
    wave = anim_phase[7] ? 8'((8'd255 - anim_phase) << 1) : 8'(anim_phase << 1);
    if (key && regs_shadow.press_enable) begin
      green = regs_shadow.press_green;
      blue  = regs_shadow.press_blue;
    end else begin
      case (regs_shadow.led_mode)
        MODE_SOLID: begin
          green = regs_shadow.base_green;
          blue  = regs_shadow.base_blue;
        end
        MODE_BREATHE: begin
          green = scale8(regs_shadow.base_green, wave);
          blue  = scale8(regs_shadow.base_blue, wave);
        end
        MODE_CYCLE: begin
          green = 8'd255 - wave;
          blue  = wave;
        end
        default: begin
          green = 8'd0;
          blue  = 8'd0;
        end
      endcase
    end
    green = scale8(green, regs_shadow.brightness);
    blue  = scale8(blue, regs_shadow.brightness);
    lv.green_level = green;
    lv.blue_level  = blue;
    lv.green_duty  = green[7:3];
    lv.blue_duty   = blue[7:3];
    lv.led_enable  = |{green, blue};
    return lv;
  endfunction

  function automatic cfg_t make_cfg(input logic [1:0] mode, input logic [7:0] bg,
                                    input logic [7:0] bb, input logic [15:0] period,
                                    input logic pe, input logic [7:0] pg,
                                    input logic [7:0] pb, input logic [7:0] bright);
    cfg_t c;
    c.led_mode     = mode;
    c.base_green   = bg;
    c.base_blue    = bb;
    c.period_ms    = period;
    c.press_enable = pe;
    c.press_green  = pg;
    c.press_blue   = pb;
    c.brightness   = bright;
    return c;
  endfunction

  function automatic logic [7:0] pick_level();
    logic [7:0] v;
    case ($urandom_range(0, 3))
      0: v = 8'd0;
      1: v = 8'd255;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.led_mode     = 2'($urandom_range(0, 3));
    c.base_green   = pick_level();
    c.base_blue    = pick_level();
    c.press_enable = 1'($urandom_range(0, 1));
    c.press_green  = pick_level();
    c.press_blue   = pick_level();
    c.brightness   = pick_level();
    case ($urandom_range(0, 9))
      0: c.period_ms = 16'hFFFF;
      1: c.period_ms = 16'($urandom);
      default: c.period_ms = 16'($urandom_range(0, 1023));
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t ns: MISMATCH %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_levels();
    levels_t want;
    if (expected_levels.size() == 0) begin
      report_mismatch("result beat with no tick pending");
    end else begin
      want = expected_levels.pop_front();
      compare_field("green_level", out_green_level, want.green_level);
      compare_field("blue_level", out_blue_level, want.blue_level);
      compare_field("green_duty", out_green_duty, want.green_duty);
      compare_field("blue_duty", out_blue_duty, want.blue_duty);
      compare_field("led_enable", out_led_enable, want.led_enable);
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      check_levels();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat on either channel for %0d cycles.", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_key_down <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_levels.push_back(next_levels(key));
    ticks_sent++;
    if (key && regs_shadow.press_enable) begin
      override_ticks++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [LDC_CFG_IDX_W-1:0] idx,
                           input logic [LDC_CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Unused upper data bits carry noise; the block must ignore them.
  task automatic set_config(input cfg_t c);
    logic [15:0] noise;
    wait_drained();
    noise = 16'($urandom);
    write_reg(CFG_LED_MODE, {noise[15:2], c.led_mode});
    write_reg(CFG_BASE_GREEN, {noise[7:0], c.base_green});
    write_reg(CFG_BASE_BLUE, {noise[15:8], c.base_blue});
    write_reg(CFG_PERIOD_MS, c.period_ms);
    write_reg(CFG_PRESS_ENABLE, {noise[14:0], c.press_enable});
    write_reg(CFG_PRESS_GREEN, {~noise[7:0], c.press_green});
    write_reg(CFG_PRESS_BLUE, {~noise[15:8], c.press_blue});
    write_reg(CFG_BRIGHTNESS, {noise[11:4], c.brightness});
    cfg_we <= 1'b0;
    @(posedge clk);
    regs_shadow = c;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_solid_and_brightness();
    set_config(make_cfg(MODE_SOLID, 8'd255, 8'd0, 16'd0, 1'b0, 8'd0, 8'd0, 8'd255));
    send_tick(1'b0);
    send_tick(1'b1);
    set_config(make_cfg(MODE_SOLID, 8'd0, 8'd255, 16'd0, 1'b0, 8'd0, 8'd0, 8'd255));
    send_tick(1'b0);
    set_config(make_cfg(MODE_SOLID, 8'd255, 8'd255, 16'd0, 1'b1, 8'd255, 8'd255, 8'd0));
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_breathe();
    set_config(make_cfg(MODE_BREATHE, 8'd255, 8'd128, 16'd255, 1'b0, 8'd0, 8'd0, 8'd255));
    repeat (3) send_tick(1'b0);
  endtask

  task automatic test_cycle();
    set_config(make_cfg(MODE_CYCLE, 8'd0, 8'd0, 16'hFFFF, 1'b1, 8'd7, 8'd200, 8'd255));
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_off_and_override();
    set_config(make_cfg(MODE_OFF, 8'd255, 8'd255, 16'd0, 1'b1, 8'd255, 8'd255, 8'd255));
    send_tick(1'b0);
    send_tick(1'b1);
    set_config(make_cfg(MODE_OFF, 8'd255, 8'd255, 16'd0, 1'b0, 8'd255, 8'd255, 8'd255));
    send_tick(1'b1);
  endtask

  // The count builds up under a long step, then the step drops below it.
  task automatic test_step_lowered();
    set_config(make_cfg(MODE_CYCLE, 8'd0, 8'd0, 16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd255));
    repeat (6) send_tick(1'b0);
    set_config(make_cfg(MODE_CYCLE, 8'd0, 8'd0, 16'h0300, 1'b0, 8'd0, 8'd0, 8'd255));
    repeat (2) send_tick(1'b0);
  endtask

  task automatic test_random_settings();
    int  set_idx;
    int  n;
    logic key_level;
    key_level = 1'b0;
    for (set_idx = 0; set_idx < RAND_SETTINGS; set_idx++) begin
      set_config(random_settings());
      case (set_idx % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      for (n = 0; n < TICKS_PER_SET; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          key_level = ~key_level;
        end
        send_tick(key_level);
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    regs_shadow            = '0;
    regs_shadow.brightness = BRIGHTNESS_RESET;
    tick_count             = 8'd0;
    anim_phase             = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_solid_and_brightness();
    test_breathe();
    test_cycle();
    test_off_and_override();
    test_step_lowered();
    test_random_settings();
    wait_drained();
    $display("Sent %0d ticks under %0d register settings, %0d of them with the press override.",
             ticks_sent, settings_used, override_ticks);
    $display("Compared %0d result beats field by field; %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
